// ----- design/sorted_region_table_redzone_checker_assert.svh -----
// Assertion macros for the region table checker
`ifndef SORTED_REGION_TABLE_REDZONE_CHECKER_ASSERT_SVH
`define SORTED_REGION_TABLE_REDZONE_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
`define SRT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRT_ASSERT_NORST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRT_ASSERT(label, clk, rst_n, prop, msg)
`define SRT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ----- design/srtrc_pkg.sv -----
`default_nettype none
package srtrc_pkg;
	localparam int unsigned MaxEntriesDef = 64;
	localparam int unsigned AddrWidthDef = 32;
	localparam int unsigned TagWidthDef = 16;

	typedef enum logic [1:0] {
		CMD_REGISTER   = 2'd0,
		CMD_UNREGISTER = 2'd1,
		CMD_CHECK      = 2'd2,
		CMD_NONE       = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_IGNORED  = 3'd1,
		ST_FULL     = 3'd2,
		ST_REMOVED  = 3'd3,
		ST_ABSENT   = 3'd4,
		ST_CLEAN    = 3'd5,
		ST_FAULT    = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BS_RD,   // binary search: issue read of mid
		S_BS_CMP,  // binary search: compare
		S_DUP_RD,
		S_DUP_CMP,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INS_WR,
		S_FIND_RD,
		S_FIND_CMP,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

// ----- design/sorted_region_table_redzone_checker.sv -----
`default_nettype none
// Sorted region table with trailing-redzone access checker.
// Request channel: drive command and its fields with start high; the request
// is taken at a rising edge where start is high and busy is low. busy stays
// high until the result goes out.
// Result channel: done pulses for one cycle with result_status, the fault
// fields and stored_entries. The receiver cannot stall; results are never
// held back.
// Check keeps busy high through a binary search (at most 7 steps for 64
// entries) and a scan of the entries from the one before the found slot.
// Register compares each equal-start entry, then moves entries up one place
// to open the insert slot. Unregister scans for the tag, then pulls the later
// entries down.
// A new request can be taken at the edge that ends the done cycle.
// The table sits in a memory with one write port and one registered read port;
// each search, scan and shift step reads one entry before its compare or write.
// Reset clears entry count and the batch abort flag; the memory contents are
// not cleared, and entries at or above the entry count are never used.
module sorted_region_table_redzone_checker
	import srtrc_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
	parameter int unsigned ADDR_WIDTH = AddrWidthDef,
	parameter int unsigned TAG_WIDTH = TagWidthDef,
	localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            command,
	input  wire logic [TAG_WIDTH-1:0]  descriptor_tag,
	input  wire logic [ADDR_WIDTH-1:0] region_begin,
	input  wire logic [ADDR_WIDTH-1:0] usable_bytes,
	input  wire logic [ADDR_WIDTH-1:0] total_size,
	input  wire logic                  batch_last,
	input  wire logic [ADDR_WIDTH-1:0] access_address,
	input  wire logic [ADDR_WIDTH-1:0] access_size,
	output logic                       done,
	output logic [2:0]                 result_status,
	output logic [ADDR_WIDTH-1:0]      fault_address,
	output logic [ADDR_WIDTH-1:0]      fault_region_start,
	output logic [ADDR_WIDTH-1:0]      fault_region_end,
	output logic [ADDR_WIDTH-1:0]      fault_usable_bytes,
	output logic [TAG_WIDTH-1:0]       fault_tag,
	output logic [6:0]                 stored_entries
);
`include "sorted_region_table_redzone_checker_assert.svh"
	localparam int unsigned EW = 3 * ADDR_WIDTH + TAG_WIDTH;
	localparam logic [ADDR_WIDTH-1:0] AMAX = '1;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, lo_q, hi_q, idx_q;
	logic aborted_q;
	logic [1:0] cmd_q;
	logic last_q;
	logic [TAG_WIDTH-1:0] tag_q;
	logic [ADDR_WIDTH-1:0] a_q, osz_q, tsz_q, aend_q;
	logic [2:0] st_q;
	logic [ADDR_WIDTH-1:0] fb_q, fs_q, fe_q, fo_q;
	logic [TAG_WIDTH-1:0] ft_q;

	logic mem_we;
	logic [IW-1:0] mem_wa, mem_ra;
	logic [EW-1:0] mem_wd, mem_rd;
	logic [ADDR_WIDTH-1:0] e_b, e_o, e_t;
	logic [TAG_WIDTH-1:0] e_tag;
	assign {e_b, e_o, e_t, e_tag} = mem_rd;

	srtrc_mem #(.DEPTH(MAX_ENTRIES), .WIDTH(EW)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd),
		.raddr(mem_ra), .rdata(mem_rd)
	);

	// address adders
	logic [ADDR_WIDTH:0] sum_in, ps_w, pe_w;
	assign sum_in = {1'b0, access_address} + {1'b0, access_size};
	assign ps_w = {1'b0, e_b} + {1'b0, e_o};
	assign pe_w = {1'b0, e_b} + {1'b0, e_t};
	logic [ADDR_WIDTH:0] rend_w;
	assign rend_w = {1'b0, region_begin} + {1'b0, total_size};

	logic [CW-1:0] mid_w;
	assign mid_w = lo_q + ((hi_q - lo_q) >> 1);

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (cmd_t'(command))
						CMD_REGISTER: begin
							if (aborted_q || usable_bytes == '0 || usable_bytes > total_size
									|| rend_w[ADDR_WIDTH]) begin
								state_d = S_DONE;
							end else begin
								state_d = S_BS_RD;
							end
						end
						CMD_UNREGISTER: state_d = S_FIND_RD;
						CMD_CHECK:      state_d = S_BS_RD;
						default:        state_d = S_DONE;
					endcase
				end
			end
			S_BS_RD:  state_d = (lo_q < hi_q) ? S_BS_CMP : ((cmd_q == CMD_CHECK) ? S_SCAN_RD : S_DUP_RD);
			S_BS_CMP: state_d = S_BS_RD;
			S_DUP_RD: state_d = (idx_q < count_q) ? S_DUP_CMP
				: ((count_q >= CW'(MAX_ENTRIES)) ? S_DONE : S_SHIFT_RD);
			S_DUP_CMP: begin
				if (e_b != a_q) begin
					state_d = (count_q >= CW'(MAX_ENTRIES)) ? S_DONE : S_SHIFT_RD;
				end else if (e_tag == tag_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_DUP_RD;
				end
			end
			S_SHIFT_RD: begin
				// removal pulls entries down until the last one, insert pushes up to lo
				if (rm_q) begin
					state_d = (idx_q + 1'b1 < count_q) ? S_SHIFT_WR : S_DONE;
				end else begin
					state_d = (idx_q > lo_q) ? S_SHIFT_WR : S_INS_WR;
				end
			end
			S_SHIFT_WR: state_d = S_SHIFT_RD;
			S_INS_WR:   state_d = S_DONE;
			S_SCAN_RD:  state_d = (idx_q < count_q) ? S_SCAN_CMP : S_DONE;
			S_SCAN_CMP: begin
				if (e_b >= aend_q) begin
					state_d = S_DONE;
				end else if (!({1'b0, a_q} >= pe_w || {1'b0, aend_q} <= ps_w)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_FIND_RD:  state_d = (idx_q < count_q) ? S_FIND_CMP : S_DONE;
			S_FIND_CMP: state_d = (e_tag == tag_q) ? S_SHIFT_RD : S_FIND_RD;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory port control
	logic rm_q; // removal shift mode
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q[IW-1:0];
		mem_wd = mem_rd;
		mem_ra = idx_q[IW-1:0];
		unique case (state_q)
			S_BS_RD:    mem_ra = mid_w[IW-1:0];
			S_SHIFT_RD: begin
				if (rm_q) mem_ra = IW'(idx_q + 1'b1);
				else      mem_ra = IW'(idx_q - 1'b1);
			end
			S_SHIFT_WR: mem_we = 1'b1;
			S_INS_WR: begin
				mem_we = 1'b1;
				mem_wa = lo_q[IW-1:0];
				mem_wd = {a_q, osz_q, tsz_q, tag_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			aborted_q <= 1'b0;
			done <= 1'b0;
			rm_q <= 1'b0;
		end else begin
			done <= (state_q == S_DONE);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						rm_q <= 1'b0;
						if (command != CMD_REGISTER && command != CMD_NONE) aborted_q <= 1'b0;
					end
				end
				S_DUP_RD: begin
					if (!(idx_q < count_q) && count_q >= CW'(MAX_ENTRIES)) aborted_q <= 1'b1;
				end
				S_DUP_CMP: begin
					if (e_b != a_q && count_q >= CW'(MAX_ENTRIES)) aborted_q <= 1'b1;
				end
				S_FIND_CMP: if (e_tag == tag_q) rm_q <= 1'b1;
				S_SHIFT_RD: begin
					if (rm_q && !(idx_q + 1'b1 < count_q)) count_q <= count_q - 1'b1;
				end
				S_INS_WR: count_q <= count_q + 1'b1;
				S_DONE: if (cmd_q == CMD_REGISTER && last_q) aborted_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q <= command;
				tag_q <= descriptor_tag;
				last_q <= batch_last;
				osz_q <= usable_bytes;
				tsz_q <= total_size;
				lo_q <= '0;
				hi_q <= count_q;
				idx_q <= '0;
				fb_q <= '0; fs_q <= '0; fe_q <= '0; fo_q <= '0; ft_q <= '0;
				if (command == CMD_CHECK) begin
					a_q <= access_address;
					aend_q <= sum_in[ADDR_WIDTH] ? AMAX : sum_in[ADDR_WIDTH-1:0];
					st_q <= ST_CLEAN;
				end else begin
					a_q <= region_begin;
					aend_q <= '0;
					if (command == CMD_UNREGISTER) st_q <= ST_ABSENT;
					else if (command == CMD_REGISTER && aborted_q) st_q <= ST_FULL;
					else st_q <= ST_IGNORED;
				end
			end
			S_BS_RD: begin
				if (!(lo_q < hi_q)) begin
					if (cmd_q == CMD_CHECK) idx_q <= (lo_q != '0) ? lo_q - 1'b1 : lo_q;
					else idx_q <= lo_q;
				end else begin
					idx_q <= mid_w;
				end
			end
			S_BS_CMP: begin
				if (e_b < a_q) lo_q <= idx_q + 1'b1;
				else           hi_q <= idx_q;
			end
			S_DUP_RD: begin
				if (!(idx_q < count_q)) begin
					if (count_q >= CW'(MAX_ENTRIES)) st_q <= ST_FULL;
					else idx_q <= count_q;
				end
			end
			S_DUP_CMP: begin
				if (e_b != a_q) begin
					if (count_q >= CW'(MAX_ENTRIES)) st_q <= ST_FULL;
					else idx_q <= count_q;
				end else if (e_tag != tag_q) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_SHIFT_WR: idx_q <= rm_q ? idx_q + 1'b1 : idx_q - 1'b1;
			S_INS_WR: st_q <= ST_INSERTED;
			S_SCAN_CMP: begin
				if (e_b < aend_q && !({1'b0, a_q} >= pe_w || {1'b0, aend_q} <= ps_w)) begin
					st_q <= ST_FAULT;
					fb_q <= ({1'b0, a_q} > ps_w) ? a_q : ps_w[ADDR_WIDTH-1:0];
					fs_q <= e_b;
					fe_q <= pe_w[ADDR_WIDTH-1:0];
					fo_q <= e_o;
					ft_q <= e_tag;
				end
				idx_q <= idx_q + 1'b1;
			end
			S_FIND_RD: ;
			S_FIND_CMP: begin
				if (e_tag == tag_q) begin
					st_q <= ST_REMOVED;
					lo_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			result_status <= st_q;
			fault_address <= fb_q;
			fault_region_start <= fs_q;
			fault_region_end <= fe_q;
			fault_usable_bytes <= fo_q;
			fault_tag <= ft_q;
			stored_entries <= 7'(count_q);
		end
	end

	`SRT_ASSERT(a_count_max, clk, arst_n, count_q <= CW'(MAX_ENTRIES), "entry count overflow")
	`SRT_ASSERT(a_done_pulse, clk, arst_n, done |=> !done, "done longer than one cycle")
	`SRT_ASSERT(a_busy_done, clk, arst_n, (state_q == S_DONE) |=> (done && !busy), "done without idle")
	`SRT_ASSERT(a_count_step, clk, arst_n, (state_q == S_IDLE) |=> $stable(count_q), "count moved at accept")
endmodule
`default_nettype wire

// ----- design/srtrc_mem.sv -----
`default_nettype none
// Entry store: one write port, one registered read port.
module srtrc_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 112,
	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [IW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- tb/sv/sorted_region_table_redzone_checker_test.sv -----
`timescale 1ns / 1ps
module sorted_region_table_redzone_checker_test;
	import srtrc_pkg::*;

	localparam int unsigned DEPTH = 64;
	localparam logic [31:0] AMAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] bad_addr;
		logic [31:0] reg_start;
		logic [31:0] reg_end;
		logic [31:0] osize;
		logic [15:0] tag;
		logic [6:0]  count;
	} region_result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] command;
	logic [15:0] descriptor_tag;
	logic [31:0] region_begin;
	logic [31:0] usable_bytes;
	logic [31:0] total_size;
	logic batch_last;
	logic [31:0] access_address;
	logic [31:0] access_size;
	logic done;
	logic [2:0] result_status;
	logic [31:0] fault_address;
	logic [31:0] fault_region_start;
	logic [31:0] fault_region_end;
	logic [31:0] fault_usable_bytes;
	logic [15:0] fault_tag;
	logic [6:0] stored_entries;

	// shadow copy of the region table
	logic [31:0] tbl_begin [DEPTH];
	logic [31:0] tbl_osize [DEPTH];
	logic [31:0] tbl_tsize [DEPTH];
	logic [15:0] tbl_tag [DEPTH];
	int unsigned tbl_count;
	bit tbl_aborted;

	region_result_t pending_results[$];
	int errors;

	sorted_region_table_redzone_checker uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.descriptor_tag(descriptor_tag), .region_begin(region_begin),
		.usable_bytes(usable_bytes), .total_size(total_size), .batch_last(batch_last),
		.access_address(access_address), .access_size(access_size), .done(done),
		.result_status(result_status), .fault_address(fault_address),
		.fault_region_start(fault_region_start), .fault_region_end(fault_region_end),
		.fault_usable_bytes(fault_usable_bytes), .fault_tag(fault_tag),
		.stored_entries(stored_entries)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int unsigned table_lower_bound(logic [31:0] addr);
		int unsigned lo, hi, mid;
		lo = 0;
		hi = tbl_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (tbl_begin[mid] < addr)
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo;
	endfunction

	function automatic logic [2:0] table_insert(logic [15:0] tag, logic [31:0] b,
			logic [31:0] osz, logic [31:0] tsz);
		int unsigned pos, i;
		if (osz == 0 || osz > tsz || b > AMAX - tsz)
			return ST_IGNORED;
		pos = table_lower_bound(b);
		for (i = pos; i < tbl_count && tbl_begin[i] == b; i++)
			if (tbl_tag[i] == tag)
				return ST_IGNORED;
		if (tbl_count >= DEPTH) begin
			tbl_aborted = 1'b1;
			return ST_FULL;
		end
		for (i = tbl_count; i > pos; i--) begin
			tbl_begin[i] = tbl_begin[i-1];
			tbl_osize[i] = tbl_osize[i-1];
			tbl_tsize[i] = tbl_tsize[i-1];
			tbl_tag[i] = tbl_tag[i-1];
		end
		tbl_begin[pos] = b;
		tbl_osize[pos] = osz;
		tbl_tsize[pos] = tsz;
		tbl_tag[pos] = tag;
		tbl_count++;
		return ST_INSERTED;
	endfunction

	function automatic logic [2:0] table_remove(logic [15:0] tag);
		int unsigned i, j;
		for (i = 0; i < tbl_count; i++) begin
			if (tbl_tag[i] != tag)
				continue;
			for (j = i; j + 1 < tbl_count; j++) begin
				tbl_begin[j] = tbl_begin[j+1];
				tbl_osize[j] = tbl_osize[j+1];
				tbl_tsize[j] = tbl_tsize[j+1];
				tbl_tag[j] = tbl_tag[j+1];
			end
			tbl_count--;
			return ST_REMOVED;
		end
		return ST_ABSENT;
	endfunction

	function automatic void redzone_search(logic [31:0] addr, logic [31:0] len,
			ref region_result_t r);
		logic [32:0] aend, ps, pe;
		int unsigned i;
		aend = {1'b0, addr} + len;
		if (aend > AMAX)
			aend = AMAX;
		r.status = ST_CLEAN;
		i = table_lower_bound(addr);
		if (i > 0)
			i--;
		for (; i < tbl_count; i++) begin
			if (tbl_begin[i] >= aend)
				break;
			ps = {1'b0, tbl_begin[i]} + tbl_osize[i];
			pe = {1'b0, tbl_begin[i]} + tbl_tsize[i];
			if (addr >= pe || aend <= ps)
				continue;
			r.status = ST_FAULT;
			r.bad_addr = (addr > ps) ? addr : ps[31:0];
			r.reg_start = tbl_begin[i];
			r.reg_end = pe[31:0];
			r.osize = tbl_osize[i];
			r.tag = tbl_tag[i];
			return;
		end
	endfunction

	function automatic region_result_t predict_request(logic [1:0] cmd, logic [15:0] tag,
			logic [31:0] b, logic [31:0] osz, logic [31:0] tsz, logic last,
			logic [31:0] addr, logic [31:0] len);
		region_result_t r;
		r = '0;
		case (cmd)
			CMD_REGISTER: begin
				r.status = tbl_aborted ? ST_FULL : table_insert(tag, b, osz, tsz);
				if (last)
					tbl_aborted = 1'b0;
			end
			CMD_UNREGISTER: begin
				tbl_aborted = 1'b0;
				r.status = table_remove(tag);
			end
			CMD_CHECK: begin
				tbl_aborted = 1'b0;
				redzone_search(addr, len, r);
			end
			default: r.status = ST_IGNORED;
		endcase
		r.count = tbl_count[6:0];
		return r;
	endfunction

	// start stays high through a zero-length gap; the next request drives it again
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			n = 0;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_request(logic [1:0] cmd, logic [15:0] tag, logic [31:0] b,
			logic [31:0] osz, logic [31:0] tsz, logic last, logic [31:0] addr,
			logic [31:0] len);
		command <= cmd;
		descriptor_tag <= tag;
		region_begin <= b;
		usable_bytes <= osz;
		total_size <= tsz;
		batch_last <= last;
		access_address <= addr;
		access_size <= len;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(predict_request(cmd, tag, b, osz, tsz, last, addr, len));
		idle_gap();
	endtask

	task automatic do_register(logic [15:0] tag, logic [31:0] b, logic [31:0] osz,
			logic [31:0] tsz, logic last);
		send_request(CMD_REGISTER, tag, b, osz, tsz, last, $urandom, $urandom);
	endtask

	task automatic do_unregister(logic [15:0] tag);
		send_request(CMD_UNREGISTER, tag, $urandom, $urandom, $urandom, 1'($urandom),
			$urandom, $urandom);
	endtask

	task automatic do_check(logic [31:0] addr, logic [31:0] len);
		send_request(CMD_CHECK, 16'($urandom), $urandom, $urandom, $urandom, 1'($urandom),
			addr, len);
	endtask

	always @(posedge clk) begin
		region_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result, status %0d", result_status);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (result_status !== e.status) begin
					$error("result_status exp %0d got %0d", e.status, result_status);
					errors++;
				end
				if (fault_address !== e.bad_addr) begin
					$error("fault_address exp %h got %h", e.bad_addr, fault_address);
					errors++;
				end
				if (fault_region_start !== e.reg_start) begin
					$error("fault_region_start exp %h got %h", e.reg_start, fault_region_start);
					errors++;
				end
				if (fault_region_end !== e.reg_end) begin
					$error("fault_region_end exp %h got %h", e.reg_end, fault_region_end);
					errors++;
				end
				if (fault_usable_bytes !== e.osize) begin
					$error("fault_usable_bytes exp %h got %h", e.osize, fault_usable_bytes);
					errors++;
				end
				if (fault_tag !== e.tag) begin
					$error("fault_tag exp %h got %h", e.tag, fault_tag);
					errors++;
				end
				if (stored_entries !== e.count) begin
					$error("stored_entries exp %0d got %0d", e.count, stored_entries);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		do_check(0, 0);
		do_check(AMAX, AMAX);
		do_register(16'h0000, 0, 0, 16, 1);              // zero size
		do_register(16'h0001, 100, 20, 10, 1);           // size above total
		do_register(16'h0002, AMAX - 4, 2, 8, 1);        // end overflows
		do_register(16'hFFFF, AMAX - 8, 4, 8, 1);        // ends right at the top
		do_register(16'h0010, 1000, 16, 32, 0);
		do_register(16'h0010, 1000, 8, 64, 0);           // duplicate
		do_register(16'h0011, 1000, 8, 16, 1);           // same start, new tag
		do_register(16'h0012, 0, AMAX, AMAX, 1);
		do_check(1010, 4);
		do_check(1016, 1);
		do_check(1008, 100);
		do_check(AMAX - 10, AMAX);                       // saturated end
		do_check(AMAX - 4, 2);
		do_check(500, 0);
		send_request(CMD_NONE, 16'h0010, 0, 1, 1, 1, 0, 1);
		do_unregister(16'h0010);
		do_unregister(16'h0010);
		do_unregister(16'h0012);
		do_unregister(16'hFFFF);
		do_unregister(16'h0011);
	endtask

	// fill past capacity, with a batch that gets cut short and then continues
	task automatic test_full_table();
		int i;
		for (i = 0; i < DEPTH + 4; i++)
			do_register(i[15:0] + 16'h100, i * 256, 8, 32 + i[3:0], (i == DEPTH + 1));
		do_register(16'h300, 40000, 8, 16, 0);
		do_register(16'h301, 40100, 8, 16, 1);
		for (i = 0; i < 30; i++)
			do_check($urandom_range(0, DEPTH * 256 + 64), $urandom_range(0, 300));
		do_register(16'h302, 50000, 8, 16, 1);           // full again, aborted and ends
		do_check(0, 1);
		for (i = 0; i < DEPTH; i++)
			do_unregister(16'($urandom_range(16'h100, 16'h100 + DEPTH - 1)));
		for (i = 0; i < DEPTH; i++)
			do_unregister(i[15:0] + 16'h100);
	endtask

	// clustered regions so checks hit redzones often
	task automatic test_random_dense();
		int i, k;
		logic [31:0] osz, base;
		for (i = 0; i < 520; i++) begin
			k = $urandom_range(0, 99);
			base = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 4096);
			osz = $urandom_range(1, 64);
			if (k < 30)
				do_register(16'($urandom_range(0, 40)), base, osz,
					osz + $urandom_range(0, 64), 1'($urandom_range(0, 1)));
			else if (k < 35)
				do_register(16'($urandom), $urandom, $urandom, $urandom,
					1'($urandom_range(0, 1)));
			else if (k < 48)
				do_unregister(($urandom_range(0, 7) == 0) ? 16'($urandom) :
					16'($urandom_range(0, 40)));
			else if (k < 97)
				do_check(base, ($urandom_range(0, 15) == 0) ? $urandom :
					$urandom_range(0, 128));
			else
				send_request(CMD_NONE, 16'($urandom), $urandom, $urandom, $urandom,
					1'($urandom), $urandom, $urandom);
		end
	endtask

	initial begin
		errors = 0;
		tbl_count = 0;
		tbl_aborted = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_NONE;
		descriptor_tag = '0;
		region_begin = '0;
		usable_bytes = '0;
		total_size = '0;
		batch_last = 1'b0;
		access_address = '0;
		access_size = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_random_dense();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
